// ===== rtl/pdfs_pkg.sv =====
`default_nettype none

package pdfs_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_ID = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_BITS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMIDITY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOOTER_BITS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_TICKS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_TICKS = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS = 3'd7;

   localparam logic [7:0] RST_STATION_ID = 8'd95;
   localparam logic [7:0] RST_INFO_BITS = 8'd0;
   localparam logic [7:0] RST_HUMIDITY = 8'd110;
   localparam logic [7:0] RST_FOOTER_BITS = 8'd184;
   localparam logic [4:0] RST_REPEAT_COUNT = 5'd20;
   localparam logic [7:0] RST_ONE_TICKS = 8'd9;
   localparam logic [7:0] RST_ZERO_TICKS = 8'd4;
   localparam logic [7:0] RST_GAP_TICKS = 8'd18;

   localparam logic [5:0] POS_START = 6'd11;
   localparam logic [4:0] SHIFT_START = 5'd11;
   localparam logic [9:0] TEMP_START = 10'd1023;

   localparam logic [5:0] POS_INFO_START = 6'd8;
   localparam logic [5:0] POS_INFO_END = 6'd14;
   localparam logic [5:0] POS_TEMP_AREA = 6'd16;
   localparam logic [5:0] POS_TEMP_START = 6'd22;
   localparam logic [5:0] POS_HUMI_START = 6'd32;
   localparam logic [5:0] POS_FOOTER_START = 6'd40;
   localparam logic [5:0] POS_FRAME_END = 6'd45;
   localparam logic [4:0] TEMP_FIRST_SHIFT = 5'd6;

   localparam logic [15:0] MASK_NARROW = 16'h0080;
   localparam logic [15:0] MASK_WIDE = 16'h8000;

   typedef struct packed {
      logic [7:0] station_id;
      logic [7:0] info_bits;
      logic [7:0] humidity;
      logic [7:0] footer_bits;
      logic [4:0] repeat_count;
      logic [7:0] one_ticks;
      logic [7:0] zero_ticks;
      logic [7:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic        enable;
      logic        load;
      logic [15:0] raw_reading;
   } step_type;

   typedef struct packed {
      logic pin_high;
      logic sending;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pdfs_core.sv =====
`default_nettype none

module pdfs_core
   import pdfs_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  cfg_type    cfg,
   input  step_type   step,
   output result_type result
);

   logic [7:0]  tick_counter_ff, tick_counter_in;
   logic [7:0]  symbol_length_ff, symbol_length_in;
   logic [5:0]  bit_position_ff, bit_position_in;
   logic [4:0]  shift_amount_ff, shift_amount_in;
   logic        wide_mask_ff, wide_mask_in;
   logic [4:0]  repeats_left_ff, repeats_left_in;
   logic [9:0]  temperature_ff, temperature_in;

   logic [15:0] src;
   logic [15:0] sel;
   logic        symbol_start;
   logic [7:0]  tick_inc;
   logic [6:0]  frac_times5;
   logic [9:0]  whole;
   logic [9:0]  converted;

   // Tenths of a degree: floor(raw / 16) * 10 + (5 * (raw mod 16)) / 8, low 10 bits.
   assign whole = step.raw_reading[13:4];
   assign frac_times5 = {1'b0, step.raw_reading[3:0], 2'b00} + 7'(step.raw_reading[3:0]);
   assign converted = {whole[6:0], 3'b000} + {whole[8:0], 1'b0} + 10'(frac_times5[6:3]);

   always_comb begin
      if (bit_position_ff < POS_INFO_START) begin
         src = 16'(cfg.station_id);
      end else if (bit_position_ff < POS_TEMP_AREA) begin
         src = 16'(cfg.info_bits);
      end else if (bit_position_ff < POS_HUMI_START) begin
         src = 16'(temperature_ff);
      end else if (bit_position_ff < POS_FOOTER_START) begin
         src = 16'(cfg.humidity);
      end else begin
         src = 16'(cfg.footer_bits);
      end
   end

   assign sel = (wide_mask_ff ? MASK_WIDE : MASK_NARROW) >> shift_amount_ff;
   assign symbol_start = (tick_counter_ff == 8'd0) && (repeats_left_ff != 5'd0);

   always_comb begin
      tick_counter_in = tick_counter_ff;
      symbol_length_in = symbol_length_ff;
      bit_position_in = bit_position_ff;
      shift_amount_in = shift_amount_ff;
      wide_mask_in = wide_mask_ff;
      repeats_left_in = repeats_left_ff;
      temperature_in = temperature_ff;
      tick_inc = 8'd0;
      if (step.enable && step.load) begin
         temperature_in = converted;
         repeats_left_in = cfg.repeat_count;
      end else if (step.enable) begin
         if (symbol_start) begin
            symbol_length_in = ((src & sel) != 16'd0) ? cfg.one_ticks : cfg.zero_ticks;
            bit_position_in = bit_position_ff + 6'd1;
            shift_amount_in = shift_amount_ff + 5'd1;
            if (bit_position_in == POS_INFO_START) begin
               shift_amount_in = 5'd0;
            end
            if (bit_position_in == POS_INFO_END) begin
               shift_amount_in = TEMP_FIRST_SHIFT;
               bit_position_in = POS_TEMP_START;
               wide_mask_in = 1'b1;
            end
            if (bit_position_in == POS_HUMI_START) begin
               shift_amount_in = 5'd0;
               wide_mask_in = 1'b0;
            end
            if (bit_position_in == POS_FOOTER_START) begin
               shift_amount_in = 5'd0;
            end
            if (bit_position_in == POS_FRAME_END) begin
               repeats_left_in = repeats_left_ff - 5'd1;
               shift_amount_in = 5'd0;
               bit_position_in = 6'd0;
               symbol_length_in = cfg.gap_ticks;
            end
         end
         tick_inc = tick_counter_ff + 8'd1;
         tick_counter_in = (tick_inc == symbol_length_in) ? 8'd0 : tick_inc;
      end
   end

   assign result.pin_high = symbol_start;
   assign result.sending = (repeats_left_in != 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_counter_ff <= 8'd0;
         symbol_length_ff <= 8'd0;
         bit_position_ff <= POS_START;
         shift_amount_ff <= SHIFT_START;
         wide_mask_ff <= 1'b0;
         repeats_left_ff <= 5'd0;
         temperature_ff <= TEMP_START;
      end else begin
         tick_counter_ff <= tick_counter_in;
         symbol_length_ff <= symbol_length_in;
         bit_position_ff <= bit_position_in;
         shift_amount_ff <= shift_amount_in;
         wide_mask_ff <= wide_mask_in;
         repeats_left_ff <= repeats_left_in;
         temperature_ff <= temperature_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pulse_distance_ook_frame_sender.sv =====
// Pulse-distance on-off-keying frame sender.
// The req_ channel carries one item per timer tick or per temperature load:
// req_tuser is the action (0 tick, 1 load) and req_tdata the signed raw reading
// in sixteenths of a degree. Each tick item gives exactly one rsp_ item with the
// pin level and a flag that stays set while frame repeats remain; a load item
// converts the reading to tenths of a degree, reloads the repeat count and gives
// no rsp_ item. The csr_ port writes the eight frame and timing registers on any
// clock edge with csr_we high, and is to be used only while the block is idle.
// An accepted item is held in the input register and, once it can advance, is
// processed into the output register, which raises rsp_tvalid. One item is
// taken per clock cycle as long as the receiver keeps up; the output register
// lets the next item enter while a result waits. When the receiver stalls, the
// output register holds its item and req_tready drops once the input register
// also holds a tick. Synchronous reset empties both registers and restores all
// register and frame state to the power-up values, with the first partial frame
// after reset opening with zero bits.
`default_nettype none

module pulse_distance_ook_frame_sender
   import pdfs_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [15:0]           req_tdata,   // raw_reading[15:0]
   input  wire                   req_tuser,   // action
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,   // pin_high, sending, zero padding
   input  wire                   csr_we,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_load_ff;
   logic [15:0] in_raw_ff;
   logic       out_valid_ff;
   result_type out_data_ff;

   step_type   step;
   result_type result;
   logic       advance;

   assign advance = in_valid_ff && (in_load_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign step.enable = advance;
   assign step.load = in_load_ff;
   assign step.raw_reading = in_raw_ff;

   pdfs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_id <= RST_STATION_ID;
         cfg_ff.info_bits <= RST_INFO_BITS;
         cfg_ff.humidity <= RST_HUMIDITY;
         cfg_ff.footer_bits <= RST_FOOTER_BITS;
         cfg_ff.repeat_count <= RST_REPEAT_COUNT;
         cfg_ff.one_ticks <= RST_ONE_TICKS;
         cfg_ff.zero_ticks <= RST_ZERO_TICKS;
         cfg_ff.gap_ticks <= RST_GAP_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STATION_ID: cfg_ff.station_id <= csr_wdata;
            CSR_INFO_BITS: cfg_ff.info_bits <= csr_wdata;
            CSR_HUMIDITY: cfg_ff.humidity <= csr_wdata;
            CSR_FOOTER_BITS: cfg_ff.footer_bits <= csr_wdata;
            CSR_REPEAT_COUNT: cfg_ff.repeat_count <= csr_wdata[4:0];
            CSR_ONE_TICKS: cfg_ff.one_ticks <= csr_wdata;
            CSR_ZERO_TICKS: cfg_ff.zero_ticks <= csr_wdata;
            CSR_GAP_TICKS: cfg_ff.gap_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_load_ff <= req_tuser;
         in_raw_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && !in_load_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !in_load_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_data_ff.sending, out_data_ff.pin_high};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import pdfs_pkg::*;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire req_tready;
   logic [15:0] req_tdata = '0;
   logic req_tuser = ACT_TICK;
   wire rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire [7:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pulse_distance_ook_frame_sender dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int results_seen = 0;
   int ticks_sent = 0;
   int loads_sent = 0;
   int cycle_count = 0;

   result_type pins_due[$];
   cfg_type csr_shadow;

   logic [7:0] sym_tick;
   logic [7:0] sym_len;
   logic [5:0] frame_pos;
   logic [4:0] bit_shift;
   logic wide_mask;
   logic [4:0] repeats_left;
   logic [9:0] temp_tenths;

   function automatic logic [9:0] tenths_of(input logic [15:0] raw);
      int whole;
      int tenths;
      whole = int'($signed(raw)) >>> 4;
      tenths = whole * 10 + (625 * int'(raw[3:0])) / 1000;
      return tenths[9:0];
   endfunction

   function automatic logic [15:0] frame_word(input logic [5:0] pos);
      if (pos < POS_INFO_START) return {8'h00, csr_shadow.station_id};
      if (pos < POS_TEMP_AREA) return {8'h00, csr_shadow.info_bits};
      if (pos < POS_HUMI_START) return {6'b0, temp_tenths};
      if (pos < POS_FOOTER_START) return {8'h00, csr_shadow.humidity};
      return {8'h00, csr_shadow.footer_bits};
   endfunction

   function automatic result_type pin_for_tick();
      result_type r;
      logic [15:0] word;
      logic [15:0] mask;
      logic [15:0] sel;
      r.pin_high = 1'b0;
      if (sym_tick == 8'd0 && repeats_left != 5'd0) begin
         word = frame_word(frame_pos);
         mask = wide_mask ? MASK_WIDE : MASK_NARROW;
         sel = (bit_shift < 5'd16) ? (mask >> bit_shift) : 16'h0000;
         r.pin_high = 1'b1;
         sym_len = ((word & sel) != 16'h0000) ? csr_shadow.one_ticks : csr_shadow.zero_ticks;
         frame_pos = frame_pos + 6'd1;
         bit_shift = bit_shift + 5'd1;
         if (frame_pos == POS_INFO_START) bit_shift = 5'd0;
         if (frame_pos == POS_INFO_END) begin
            bit_shift = TEMP_FIRST_SHIFT;
            frame_pos = POS_TEMP_START;
            wide_mask = 1'b1;
         end
         if (frame_pos == POS_HUMI_START) begin
            bit_shift = 5'd0;
            wide_mask = 1'b0;
         end
         if (frame_pos == POS_FOOTER_START) bit_shift = 5'd0;
         if (frame_pos == POS_FRAME_END) begin
            repeats_left = repeats_left - 5'd1;
            bit_shift = 5'd0;
            frame_pos = 6'd0;
            sym_len = csr_shadow.gap_ticks;
         end
      end
      sym_tick = sym_tick + 8'd1;
      if (sym_tick == sym_len) sym_tick = 8'd0;
      r.sending = (repeats_left != 5'd0);
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[pulse_distance_ook_frame_sender] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                  what, cycle_count, want, got);
   endtask

   always @(posedge clock) begin : check_rsp
      result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pins_due.size() == 0) begin
            flag_mismatch("unexpected rsp item", 0, rsp_tdata);
         end else begin
            due = pins_due.pop_front();
            if (rsp_tdata[0] !== due.pin_high)
               flag_mismatch("pin_high", due.pin_high, rsp_tdata[0]);
            if (rsp_tdata[1] !== due.sending)
               flag_mismatch("sending", due.sending, rsp_tdata[1]);
            if (rsp_tdata[7:2] !== 6'b0)
               flag_mismatch("padding", 0, rsp_tdata[7:2]);
         end
      end
   end

   task automatic send_item(input logic act, input logic [15:0] raw);
      int gap_cycles;
      gap_cycles = 0;
      while ($urandom_range(99) < sender_idle_pct) gap_cycles++;
      if (gap_cycles != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= raw;
      do @(posedge clock); while (!req_tready);
      if (act == ACT_LOAD) begin
         temp_tenths = tenths_of(raw);
         repeats_left = csr_shadow.repeat_count;
         loads_sent++;
      end else begin
         pins_due.push_back(pin_for_tick());
         ticks_sent++;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_STATION_ID: csr_shadow.station_id = val;
         CSR_INFO_BITS: csr_shadow.info_bits = val;
         CSR_HUMIDITY: csr_shadow.humidity = val;
         CSR_FOOTER_BITS: csr_shadow.footer_bits = val;
         CSR_REPEAT_COUNT: csr_shadow.repeat_count = val[4:0];
         CSR_ONE_TICKS: csr_shadow.one_ticks = val;
         CSR_ZERO_TICKS: csr_shadow.zero_ticks = val;
         CSR_GAP_TICKS: csr_shadow.gap_ticks = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(CSR_STATION_ID, c.station_id);
      write_reg(CSR_INFO_BITS, c.info_bits);
      write_reg(CSR_HUMIDITY, c.humidity);
      write_reg(CSR_FOOTER_BITS, c.footer_bits);
      write_reg(CSR_REPEAT_COUNT, {3'($urandom), c.repeat_count});
      write_reg(CSR_ONE_TICKS, c.one_ticks);
      write_reg(CSR_ZERO_TICKS, c.zero_ticks);
      write_reg(CSR_GAP_TICKS, c.gap_ticks);
      csr_wdata <= 8'($urandom);
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type random_config(input int max_len);
      cfg_type c;
      c.station_id = 8'($urandom);
      c.info_bits = 8'($urandom);
      c.humidity = 8'($urandom);
      c.footer_bits = 8'($urandom);
      c.repeat_count = 5'($urandom_range(1, 3));
      c.one_ticks = 8'($urandom_range(1, max_len));
      c.zero_ticks = 8'($urandom_range(1, max_len));
      c.gap_ticks = 8'($urandom_range(1, max_len));
      return c;
   endfunction

   task automatic run_items(input int count, input int load_pct);
      send_item(ACT_LOAD, 16'($urandom));
      for (int i = 1; i < count; i++) begin
         if ($urandom_range(99) < load_pct) send_item(ACT_LOAD, 16'($urandom));
         else send_item(ACT_TICK, 16'($urandom));
      end
   endtask

   // Runs on the power-up registers, so the first partial frame opens with zero bits.
   task automatic test_power_up_frame();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_item(ACT_LOAD, 16'h8000);
      send_item(ACT_LOAD, 16'h7FFF);
      send_item(ACT_LOAD, 16'hFFFF);
      send_item(ACT_LOAD, 16'h000F);
      send_item(ACT_LOAD, 16'h0199);
      repeat (20) send_item(ACT_TICK, 16'($urandom));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int idle_modes[4] = '{0, 66, 0, 11};
      int stall_modes[4] = '{0, 0, 66, 11};
      for (int m = 0; m < 4; m++) begin
         apply_config(random_config(4));
         sender_idle_pct = idle_modes[m];
         receiver_stall_pct = stall_modes[m];
         run_items(35, 3);
         if (m == 2) wait_drained();
         run_items(35, 3);
         wait_drained();
      end
   endtask

   task automatic test_length_extremes();
      cfg_type c;
      sender_idle_pct = 11;
      receiver_stall_pct = 11;
      c = '{station_id: 8'h80, info_bits: 8'h00, humidity: 8'h00, footer_bits: 8'h00,
            repeat_count: 5'd31, one_ticks: 8'd255, zero_ticks: 8'd1, gap_ticks: 8'd255};
      apply_config(c);
      send_item(ACT_LOAD, 16'h0000);
      repeat (260) send_item(ACT_TICK, 16'($urandom));
      wait_drained();
      c = '{station_id: 8'hFF, info_bits: 8'hFF, humidity: 8'hFF, footer_bits: 8'hFF,
            repeat_count: 5'd31, one_ticks: 8'd1, zero_ticks: 8'd255, gap_ticks: 8'd1};
      apply_config(c);
      send_item(ACT_LOAD, 16'h7FFF);
      repeat (40) send_item(ACT_TICK, 16'($urandom));
      wait_drained();
      c.repeat_count = 5'd0;
      apply_config(c);
      send_item(ACT_LOAD, 16'($urandom));
      repeat (20) send_item(ACT_TICK, 16'($urandom));
      wait_drained();
   endtask

   initial begin
      csr_shadow = '{station_id: RST_STATION_ID, info_bits: RST_INFO_BITS,
                     humidity: RST_HUMIDITY, footer_bits: RST_FOOTER_BITS,
                     repeat_count: RST_REPEAT_COUNT, one_ticks: RST_ONE_TICKS,
                     zero_ticks: RST_ZERO_TICKS, gap_ticks: RST_GAP_TICKS};
      sym_tick = 8'd0;
      sym_len = 8'd0;
      frame_pos = POS_START;
      bit_shift = SHIFT_START;
      wide_mask = 1'b0;
      repeats_left = 5'd0;
      temp_tenths = TEMP_START;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_up_frame();
      test_random_traffic();
      test_length_extremes();
      wait_drained();
      $display("Sent %0d tick items and %0d load items, checked %0d pin levels.",
               ticks_sent, loads_sent, results_seen);
      $display("Covered power-up frame, random frame settings under idling, and extreme lengths.");
      if (mismatches == 0 && pins_due.size() == 0) begin
         $display("[pulse_distance_ook_frame_sender] OK");
      end else begin
         $display("[pulse_distance_ook_frame_sender] ERROR");
      end
      $finish;
   end

endmodule
